### rtl/core/ifpc_pkg.sv
`default_nettype none

package ifpc_pkg;

	// Character codes recognised by the classifier.
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_Z      = 8'h7A;

	// Character classes handed from the front to the back.
	typedef logic [2:0] cls_t;
	localparam cls_t CLS_DIGIT  = 3'd0;
	localparam cls_t CLS_LETTER = 3'd1;
	localparam cls_t CLS_LPAREN = 3'd2;
	localparam cls_t CLS_RPAREN = 3'd3;
	localparam cls_t CLS_OP     = 3'd4;
	localparam cls_t CLS_OTHER  = 3'd5;

	// Operator codes; the stack also holds the parenthesis marker.
	typedef logic [1:0] opc_t;
	localparam opc_t OP_ADD = 2'd0;
	localparam opc_t OP_SUB = 2'd1;
	localparam opc_t OP_MUL = 2'd2;
	localparam opc_t OP_DIV = 2'd3;

	typedef logic [2:0] stk_t;
	localparam stk_t PAREN_CODE = 3'd4;

	// Token kinds on the output channel.
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_NUM = 2'd0;
	localparam kind_t KIND_VAR = 2'd1;
	localparam kind_t KIND_OP  = 2'd2;
	localparam kind_t KIND_END = 2'd3;

	localparam int NUM_W = 31;

	// Short queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		cls_t       cls;
		logic [4:0] val;
		logic       last;
	} cmd_t;

	typedef struct packed {
		kind_t            token_kind;
		logic [NUM_W-1:0] number_value;
		logic [4:0]       variable_index;
		opc_t             operator_code;
		logic             expression_ok;
		logic             last_result;
	} tok_t;

endpackage

`default_nettype wire

### rtl/core/ifpc_if.sv
`default_nettype none

interface ifpc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ifpc_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [30:0] number_value;
	logic [4:0]  variable_index;
	logic [1:0]  operator_code;
	logic        expression_ok;
	logic        last_result;

	modport source (output valid, output token_kind, output number_value,
		output variable_index, output operator_code, output expression_ok,
		output last_result, input ready);
	modport sink (input valid, input token_kind, input number_value,
		input variable_index, input operator_code, input expression_ok,
		input last_result, output ready);
endinterface

`default_nettype wire

### rtl/core/ifpc_ram.sv
`default_nettype none

module ifpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/ifpc_fifo.sv
`default_nettype none

module ifpc_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ifpc_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output ifpc_pkg::cmd_t     pop_data,
	output logic               not_empty
);

	ifpc_pkg::cmd_t                entry_q [ifpc_pkg::QUEUE_DEPTH];
	logic [ifpc_pkg::QPW-1:0]      wr_ptr_q;
	logic [ifpc_pkg::QPW-1:0]      rd_ptr_q;
	logic [ifpc_pkg::QCW-1:0]      fill_q;

	localparam logic [ifpc_pkg::QPW-1:0] LAST_PTR = ifpc_pkg::QPW'(ifpc_pkg::QUEUE_DEPTH - 1);

	assign full      = (fill_q == ifpc_pkg::QCW'(ifpc_pkg::QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/ifpc_front.sv
`default_nettype none

module ifpc_front (
	ifpc_char_if.sink      char_in,
	input  wire logic      q_full,
	output logic           q_push,
	output ifpc_pkg::cmd_t q_data
);

	logic [7:0] code;
	logic [7:0] digit_off;
	logic [7:0] letter_off;

	assign code       = char_in.char_code;
	assign digit_off  = code - ifpc_pkg::CH_0;
	assign letter_off = code - ifpc_pkg::CH_A;

	assign char_in.ready = !q_full;
	assign q_push        = char_in.valid && !q_full;

	// Sort each character into its class and pre-compute its small value.
	always_comb begin
		q_data.cls  = ifpc_pkg::CLS_OTHER;
		q_data.val  = '0;
		q_data.last = char_in.last_char;
		if (code >= ifpc_pkg::CH_0 && code <= ifpc_pkg::CH_9) begin
			q_data.cls = ifpc_pkg::CLS_DIGIT;
			q_data.val = digit_off[4:0];
		end else if (code >= ifpc_pkg::CH_A && code <= ifpc_pkg::CH_Z) begin
			q_data.cls = ifpc_pkg::CLS_LETTER;
			q_data.val = letter_off[4:0];
		end else begin
			case (code)
				ifpc_pkg::CH_PLUS: begin
					q_data.cls = ifpc_pkg::CLS_OP;
					q_data.val = {3'b000, ifpc_pkg::OP_ADD};
				end
				ifpc_pkg::CH_MINUS: begin
					q_data.cls = ifpc_pkg::CLS_OP;
					q_data.val = {3'b000, ifpc_pkg::OP_SUB};
				end
				ifpc_pkg::CH_STAR: begin
					q_data.cls = ifpc_pkg::CLS_OP;
					q_data.val = {3'b000, ifpc_pkg::OP_MUL};
				end
				ifpc_pkg::CH_SLASH: begin
					q_data.cls = ifpc_pkg::CLS_OP;
					q_data.val = {3'b000, ifpc_pkg::OP_DIV};
				end
				ifpc_pkg::CH_LPAREN: begin
					q_data.cls = ifpc_pkg::CLS_LPAREN;
				end
				ifpc_pkg::CH_RPAREN: begin
					q_data.cls = ifpc_pkg::CLS_RPAREN;
				end
				default: begin
					q_data.cls = ifpc_pkg::CLS_OTHER;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/ifpc_back.sv
`default_nettype none

module ifpc_back #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_valid,
	input  wire ifpc_pkg::cmd_t q_data,
	output logic           q_pop,
	ifpc_token_if.source   token_out
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int NW = ifpc_pkg::NUM_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_WAIT_X = 3'd2;
	localparam logic [2:0] ST_WAIT_F = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0]        state_q, n_state;
	logic [CW-1:0]     cnt_q, n_cnt;
	logic              exp_q, n_exp;
	logic [NW-1:0]     acc_q, n_acc;
	logic              innum_q, n_innum;
	logic              err_q, n_err;
	ifpc_pkg::cmd_t    cmd_q;

	logic              out_valid_q;
	ifpc_pkg::tok_t    out_tok_q;

	logic              emit;
	ifpc_pkg::tok_t    emit_tok;
	logic              push;
	ifpc_pkg::stk_t    push_code;
	logic              pop_req;
	logic              out_free;
	logic              stall;

	logic [CW-1:0]     cnt_dec;
	logic              stk_full;
	logic              stk_empty;
	ifpc_pkg::stk_t    top;
	logic [2:0]        done_state;
	logic [NW+3:0]     acc_next;
	logic [NW+3:0]     digit_ext;
	ifpc_pkg::opc_t    cmd_op;

	assign cnt_dec   = cnt_q - CW'(1);
	assign stk_full  = (cnt_q == CW'(STACK_DEPTH));
	assign stk_empty = (cnt_q == '0);
	assign cmd_op    = cmd_q.val[1:0];
	assign done_state = cmd_q.last ? ST_WAIT_F : ST_IDLE;

	// Decimal accumulate as shift-and-add; the top four bits flag overflow.
	assign digit_ext = {{(NW-1){1'b0}}, cmd_q.val};
	assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + digit_ext;

	// Operator stack; the read port always looks at the top entry.
	ifpc_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (push && !stall),
		.waddr (cnt_q[AW-1:0]),
		.wdata (push_code),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (top)
	);

	assign out_free = !out_valid_q || token_out.ready;
	assign stall    = emit && !out_free;
	assign q_pop    = pop_req && !stall;

	always_comb begin
		n_state   = state_q;
		n_cnt     = cnt_q;
		n_exp     = exp_q;
		n_acc     = acc_q;
		n_innum   = innum_q;
		n_err     = err_q;
		emit      = 1'b0;
		emit_tok  = '0;
		push      = 1'b0;
		push_code = ifpc_pkg::PAREN_CODE;
		pop_req   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop_req = 1'b1;
					n_state = ST_EXEC;
				end
			end

			ST_EXEC: begin
				if (err_q) begin
					n_state = done_state;
				end else if (cmd_q.cls == ifpc_pkg::CLS_DIGIT) begin
					n_state = done_state;
					if (innum_q) begin
						if (acc_next[NW+3:NW] != '0) begin
							n_err = 1'b1;
						end else begin
							n_acc = acc_next[NW-1:0];
						end
					end else if (!exp_q) begin
						n_err = 1'b1;
					end else begin
						n_innum = 1'b1;
						n_acc   = NW'(cmd_q.val);
						n_exp   = 1'b0;
					end
				end else if (innum_q) begin
					// A pending number goes out before the character itself.
					emit                  = 1'b1;
					emit_tok.token_kind   = ifpc_pkg::KIND_NUM;
					emit_tok.number_value = acc_q;
					n_innum               = 1'b0;
					n_acc                 = '0;
				end else begin
					case (cmd_q.cls)
						ifpc_pkg::CLS_LETTER: begin
							n_state = done_state;
							if (!exp_q) begin
								n_err = 1'b1;
							end else begin
								emit                    = 1'b1;
								emit_tok.token_kind     = ifpc_pkg::KIND_VAR;
								emit_tok.variable_index = cmd_q.val;
								n_exp                   = 1'b0;
							end
						end
						ifpc_pkg::CLS_LPAREN: begin
							n_state = done_state;
							if (!exp_q || stk_full) begin
								n_err = 1'b1;
							end else begin
								push      = 1'b1;
								push_code = ifpc_pkg::PAREN_CODE;
								n_cnt     = cnt_q + CW'(1);
								n_exp     = 1'b1;
							end
						end
						ifpc_pkg::CLS_RPAREN: begin
							if (exp_q || stk_empty) begin
								n_err   = 1'b1;
								n_state = done_state;
							end else if (top == ifpc_pkg::PAREN_CODE) begin
								n_cnt   = cnt_dec;
								n_exp   = 1'b0;
								n_state = done_state;
							end else begin
								emit                   = 1'b1;
								emit_tok.token_kind    = ifpc_pkg::KIND_OP;
								emit_tok.operator_code = top[1:0];
								n_cnt                  = cnt_dec;
								n_state                = ST_WAIT_X;
							end
						end
						ifpc_pkg::CLS_OP: begin
							if (exp_q) begin
								n_err   = 1'b1;
								n_state = done_state;
							end else if (!stk_empty && top != ifpc_pkg::PAREN_CODE
									&& !(!top[1] && cmd_op[1])) begin
								emit                   = 1'b1;
								emit_tok.token_kind    = ifpc_pkg::KIND_OP;
								emit_tok.operator_code = top[1:0];
								n_cnt                  = cnt_dec;
								n_state                = ST_WAIT_X;
							end else if (stk_full) begin
								n_err   = 1'b1;
								n_state = done_state;
							end else begin
								push      = 1'b1;
								push_code = {1'b0, cmd_op};
								n_cnt     = cnt_q + CW'(1);
								n_exp     = 1'b1;
								n_state   = done_state;
							end
						end
						default: begin
							n_err   = 1'b1;
							n_state = done_state;
						end
					endcase
				end
			end

			ST_WAIT_X: begin
				n_state = ST_EXEC;
			end

			ST_WAIT_F: begin
				n_state = ST_FIN;
			end

			ST_FIN: begin
				if (!err_q && innum_q) begin
					emit                  = 1'b1;
					emit_tok.token_kind   = ifpc_pkg::KIND_NUM;
					emit_tok.number_value = acc_q;
					n_innum               = 1'b0;
					n_acc                 = '0;
				end else if (!err_q && exp_q) begin
					n_err = 1'b1;
				end else if (!err_q && !stk_empty) begin
					if (top == ifpc_pkg::PAREN_CODE) begin
						n_err = 1'b1;
					end else begin
						emit                   = 1'b1;
						emit_tok.token_kind    = ifpc_pkg::KIND_OP;
						emit_tok.operator_code = top[1:0];
						n_cnt                  = cnt_dec;
						n_state                = ST_WAIT_F;
					end
				end else begin
					emit                   = 1'b1;
					emit_tok.token_kind    = ifpc_pkg::KIND_END;
					emit_tok.expression_ok = !err_q;
					emit_tok.last_result   = 1'b1;
					n_cnt                  = '0;
					n_exp                  = 1'b1;
					n_acc                  = '0;
					n_innum                = 1'b0;
					n_err                  = 1'b0;
					n_state                = ST_IDLE;
				end
			end

			default: begin
				n_state = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (emit && out_free) begin
			out_tok_q <= emit_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			exp_q       <= 1'b1;
			acc_q       <= '0;
			innum_q     <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!stall) begin
				state_q <= n_state;
				cnt_q   <= n_cnt;
				exp_q   <= n_exp;
				acc_q   <= n_acc;
				innum_q <= n_innum;
				err_q   <= n_err;
			end
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (token_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign token_out.valid          = out_valid_q;
	assign token_out.token_kind     = out_tok_q.token_kind;
	assign token_out.number_value   = out_tok_q.number_value;
	assign token_out.variable_index = out_tok_q.variable_index;
	assign token_out.operator_code  = out_tok_q.operator_code;
	assign token_out.expression_ok  = out_tok_q.expression_ok;
	assign token_out.last_result    = out_tok_q.last_result;

endmodule

`default_nettype wire

### rtl/core/infix_to_postfix_converter_unit.sv
// Infix to postfix converter.
// The char_in channel takes an infix expression one character per request:
// digits, the letters a to z, + - * / and parentheses, with last_char set on
// the final character. The token_out channel returns postfix tokens (numbers,
// variables, operators) in shunting-yard order, closed by one end status
// request that carries expression_ok and has last_result set.
// A character is classified as it is accepted and waits in a two-entry queue
// until the sequencer behind it is free, so input keeps flowing while a token
// waits at the output. The sequencer takes each character from the queue in its
// idle state and handles it in its execute state; an operator popped from the
// stack passes through a wait state, as the stack memory's read port is
// registered, and an ending number takes an execute step of its own. After the
// last character the final state emits the number, the operators and end status.
// Reset empties the queue, the stack and the output register and leaves the
// block waiting for an operand; the stack memory itself is not cleared.
// If the receiver holds ready low, the output request stays put, the
// sequencer waits, and once the queue fills char_in.ready falls.
// After an error, characters are read and dropped up to the last one, which
// yields only the end status with expression_ok low.
`default_nettype none

module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ifpc_char_if.sink      char_in,
	ifpc_token_if.source   token_out
);

	logic           q_push;
	logic           q_full;
	ifpc_pkg::cmd_t q_in;
	logic           q_pop;
	logic           q_valid;
	ifpc_pkg::cmd_t q_out;

	// Front: accepts each character and sorts it into a command.
	ifpc_front u_front (
		.char_in (char_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_in)
	);

	// Queue that decouples character intake from stack work.
	ifpc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.not_empty (q_valid)
	);

	// Back: runs the operator stack and drives the output register.
	ifpc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.token_out (token_out)
	);

endmodule

`default_nettype wire

### rtl/core/ifpc_checker.sv
`default_nettype none

module ifpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  token_kind,
	input wire logic [30:0] number_value,
	input wire logic [4:0]  variable_index,
	input wire logic [1:0]  operator_code,
	input wire logic        expression_ok,
	input wire logic        last_result
);

	// A stalled token keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
			&& $stable(number_value) && $stable(variable_index)
			&& $stable(operator_code) && $stable(last_result))
		else $error("token changed while stalled");

	// Only the end status closes an expression.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_result == (token_kind == ifpc_pkg::KIND_END)))
		else $error("last_result disagrees with token kind");

	// Status only on the end item.
	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expression_ok |-> last_result)
		else $error("expression_ok outside end status");

	// Unused fields stay zero and letters stay in range.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (token_kind == ifpc_pkg::KIND_NUM || number_value == '0)
			&& (token_kind == ifpc_pkg::KIND_OP || operator_code == '0)
			&& (token_kind == ifpc_pkg::KIND_VAR || variable_index == '0)
			&& variable_index <= 5'd25)
		else $error("token field out of place");

endmodule

bind infix_to_postfix_converter_unit ifpc_checker u_ifpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (token_out.valid),
	.out_ready      (token_out.ready),
	.token_kind     (token_out.token_kind),
	.number_value   (token_out.number_value),
	.variable_index (token_out.variable_index),
	.operator_code  (token_out.operator_code),
	.expression_ok  (token_out.expression_ok),
	.last_result    (token_out.last_result)
);

`default_nettype wire

### tb/sv/infix_to_postfix_converter_unit_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
	import ifpc_pkg::*;

	// The default stack depth of the block is kept so that the depth tests
	// below fill it exactly and then push one entry too many.
	localparam int STACK_DEPTH = 32;
	// Cycles in a row with no request moving on either channel before the run
	// is declared hung. A healthy run never comes near this even with the
	// heaviest idling, as both channels stall at random and never for long.
	localparam int QUIET_LIMIT = 2000;
	// Cycles allowed for the pipeline to settle once every token has arrived.
	localparam int SETTLE_CYCLES = 20;

	logic clk;
	logic arst_n;

	ifpc_char_if  char_bus ();
	ifpc_token_if token_bus ();

	infix_to_postfix_converter_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_in(char_bus),
		.token_out(token_bus)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Percentages of cycles in which the character sender holds back and in
	// which the token receiver drops ready. The main sequence changes them
	// between phases.
	int send_gap_pct;
	int recv_stall_pct;
	int mismatch_count;
	// Characters accepted while the expression was still free of errors; the
	// random phases use this to decide when they have sent enough.
	int live_chars;

	// Shadow of the converter state, kept in step with every accepted request.
	stk_t        held_ops [STACK_DEPTH];
	int          held_count;
	logic        awaiting_operand;
	logic [30:0] digit_value;
	logic        digits_open;
	logic        syntax_fault;

	// Postfix tokens that the block still owes, oldest first.
	tok_t postfix_due [$];

	function automatic void emit_token(kind_t kind, logic [30:0] number, logic [4:0] letter,
			opc_t opcode, logic ok, logic closing);
		tok_t t;
		t.token_kind     = kind;
		t.number_value   = number;
		t.variable_index = letter;
		t.operator_code  = opcode;
		t.expression_ok  = ok;
		t.last_result    = closing;
		postfix_due.push_back(t);
	endfunction

	function automatic void clear_converter();
		held_count       = 0;
		awaiting_operand = 1'b1;
		digit_value      = '0;
		digits_open      = 1'b0;
		syntax_fault     = 1'b0;
	endfunction

	// A number token leaves as soon as any non-digit follows it.
	function automatic void flush_pending_number();
		if (digits_open) begin
			emit_token(KIND_NUM, digit_value, 5'd0, OP_ADD, 1'b0, 1'b0);
			digits_open = 1'b0;
			digit_value = '0;
		end
	endfunction

	// Pushing onto a full stack is an overflow error and leaves it unchanged.
	function automatic logic push_held(stk_t code);
		if (held_count >= STACK_DEPTH) begin
			syntax_fault = 1'b1;
			return 1'b0;
		end
		held_ops[held_count] = code;
		held_count++;
		return 1'b1;
	endfunction

	// One character of the expression under the shunting-yard rule.
	function automatic void step_char(logic [7:0] c);
		logic [63:0] grown;
		opc_t        code;
		stk_t        top;
		logic        found;
		if (c >= CH_0 && c <= CH_9) begin
			if (digits_open) begin
				grown = 64'(digit_value) * 64'd10 + 64'(c - CH_0);
				if (grown > 64'h7FFF_FFFF)
					syntax_fault = 1'b1;
				else
					digit_value = grown[30:0];
			end else if (!awaiting_operand) begin
				syntax_fault = 1'b1;
			end else begin
				digits_open      = 1'b1;
				digit_value      = 31'(c - CH_0);
				awaiting_operand = 1'b0;
			end
		end else begin
			flush_pending_number();
			if (c >= CH_A && c <= CH_Z) begin
				if (!awaiting_operand) begin
					syntax_fault = 1'b1;
				end else begin
					emit_token(KIND_VAR, 31'd0, 5'(c - CH_A), OP_ADD, 1'b0, 1'b0);
					awaiting_operand = 1'b0;
				end
			end else if (c == CH_LPAREN) begin
				if (!awaiting_operand)
					syntax_fault = 1'b1;
				else if (push_held(PAREN_CODE))
					awaiting_operand = 1'b1;
			end else if (c == CH_RPAREN) begin
				if (awaiting_operand) begin
					syntax_fault = 1'b1;
				end else begin
					found = 1'b0;
					while (held_count > 0 && !found) begin
						top = held_ops[held_count - 1];
						held_count--;
						if (top == PAREN_CODE)
							found = 1'b1;
						else
							emit_token(KIND_OP, 31'd0, 5'd0, opc_t'(top[1:0]), 1'b0, 1'b0);
					end
					if (!found)
						syntax_fault = 1'b1;
					else
						awaiting_operand = 1'b0;
				end
			end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
				case (c)
					CH_PLUS:  code = OP_ADD;
					CH_MINUS: code = OP_SUB;
					CH_STAR:  code = OP_MUL;
					default:  code = OP_DIV;
				endcase
				if (awaiting_operand) begin
					syntax_fault = 1'b1;
				end else begin
					// Pop while the top binds at least as tightly: left associativity.
					while (held_count > 0 && held_ops[held_count - 1] != PAREN_CODE &&
							held_ops[held_count - 1][1] >= code[1]) begin
						top = held_ops[held_count - 1];
						emit_token(KIND_OP, 31'd0, 5'd0, opc_t'(top[1:0]), 1'b0, 1'b0);
						held_count--;
					end
					if (push_held(stk_t'(code)))
						awaiting_operand = 1'b1;
				end
			end else begin
				syntax_fault = 1'b1;
			end
		end
	endfunction

	// The final flush: a pending number, then the stack, then the end status.
	function automatic void close_expression();
		if (!syntax_fault) begin
			flush_pending_number();
			if (awaiting_operand)
				syntax_fault = 1'b1;
		end
		while (!syntax_fault && held_count > 0) begin
			if (held_ops[held_count - 1] == PAREN_CODE) begin
				syntax_fault = 1'b1;
			end else begin
				emit_token(KIND_OP, 31'd0, 5'd0, opc_t'(held_ops[held_count - 1][1:0]),
					1'b0, 1'b0);
				held_count--;
			end
		end
		emit_token(KIND_END, 31'd0, 5'd0, OP_ADD, !syntax_fault, 1'b1);
	endfunction

	// Characters after an error are dropped; the last one still closes.
	function automatic void convert_char(logic [7:0] c, logic last);
		if (!syntax_fault)
			step_char(c);
		if (last) begin
			close_expression();
			clear_converter();
		end
	endfunction

	// Sends one character request. Valid is only lowered in a gap, so it is
	// never lowered and raised again within the same time step.
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_gap_pct) begin
			char_bus.valid <= 1'b0;
			@(posedge clk);
		end
		char_bus.valid     <= 1'b1;
		char_bus.char_code <= c;
		char_bus.last_char <= last;
		do @(posedge clk); while (!char_bus.ready);
		if (!syntax_fault)
			live_chars++;
		convert_char(c, last);
	endtask

	task automatic send_chars(input logic [7:0] chars [$]);
		foreach (chars[i])
			send_char(chars[i], i == chars.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] chars [$];
		for (int i = 0; i < s.len(); i++)
			chars.push_back(s[i]);
		send_chars(chars);
	endtask

	// The sender stops until the block has delivered everything it owes.
	task automatic drain_tokens();
		char_bus.valid <= 1'b0;
		do @(posedge clk); while (postfix_due.size() != 0);
	endtask

	function automatic logic [7:0] random_operator();
		case ($urandom_range(3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Builds a well-formed expression: operands joined by operators, with
	// parentheses opened before operands and closed after them. Now and then
	// a number runs to ten digits, which may overflow.
	task automatic build_expression(ref logic [7:0] chars [$]);
		int terms;
		int open_count;
		int ndig;
		terms      = $urandom_range(1, 8);
		open_count = 0;
		for (int i = 0; i < terms; i++) begin
			while (open_count < 8 && $urandom_range(99) < 25) begin
				chars.push_back(CH_LPAREN);
				open_count++;
			end
			if ($urandom_range(1)) begin
				chars.push_back(8'(CH_A + $urandom_range(25)));
			end else begin
				ndig = ($urandom_range(19) == 0) ? 10 : $urandom_range(1, 4);
				repeat (ndig)
					chars.push_back(8'(CH_0 + $urandom_range(9)));
			end
			while (open_count > 0 && $urandom_range(99) < 30) begin
				chars.push_back(CH_RPAREN);
				open_count--;
			end
			if (i < terms - 1)
				chars.push_back(random_operator());
		end
		repeat (open_count)
			chars.push_back(CH_RPAREN);
	endtask

	task automatic test_precedence();
		send_text("a+b*c-d/e");
		send_text("a-b-c");
		send_text("a/b*c+d");
		send_text("x*y+z");
	endtask

	task automatic test_parentheses();
		send_text("(a+b)*(c-d)");
		send_text("((7))");
		send_text("(a");
		send_text("a)");
		send_text("()");
	endtask

	task automatic test_numbers();
		send_text("0");
		send_text("2147483647");
		send_text("2147483648");
		send_text("0000000000012+345");
		send_text("99999999999+a");
	endtask

	task automatic test_misplaced_tokens();
		send_text("ab");
		send_text("1(");
		send_text("3a");
		send_text("+a");
		send_text("a+");
		send_text("a*)");
	endtask

	// Unknown codes, a space among them; the tokens that came before the bad
	// character stand, and everything after it up to the last is dropped.
	task automatic test_unknown_chars();
		send_char(8'h20, 1'b1);
		send_char(CH_A, 1'b0);
		send_char(CH_PLUS, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(CH_RPAREN, 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'h80, 1'b0);
		send_char(CH_Z, 1'b1);
	endtask

	// A stack filled exactly to its depth and emptied again, then overflow
	// from an operator push and from a parenthesis push.
	task automatic test_stack_depth();
		logic [7:0] chars [$];
		repeat (STACK_DEPTH - 1) chars.push_back(CH_LPAREN);
		chars.push_back(CH_A);
		chars.push_back(CH_PLUS);
		chars.push_back(CH_0 + 8'd5);
		repeat (STACK_DEPTH - 1) chars.push_back(CH_RPAREN);
		send_chars(chars);

		chars.delete();
		repeat (STACK_DEPTH) chars.push_back(CH_LPAREN);
		chars.push_back(CH_A);
		chars.push_back(CH_STAR);
		chars.push_back(CH_A + 8'd1);
		repeat (STACK_DEPTH) chars.push_back(CH_RPAREN);
		send_chars(chars);

		chars.delete();
		repeat (STACK_DEPTH + 1) chars.push_back(CH_LPAREN);
		chars.push_back(CH_A);
		send_chars(chars);
		drain_tokens();
	endtask

	// Mostly well-formed expressions with random content, the rest broken
	// ones and raw noise across the whole code range.
	task automatic test_random_traffic(input int items);
		logic [7:0] chars [$];
		int start;
		int idx;
		start = live_chars;
		drain_tokens();
		while (live_chars - start < items) begin
			chars.delete();
			case ($urandom_range(19))
				0, 1, 2: begin
					repeat ($urandom_range(1, 6))
						chars.push_back(8'($urandom_range(255)));
				end
				3, 4, 5: begin
					build_expression(chars);
					idx = $urandom_range(chars.size() - 1);
					case ($urandom_range(2))
						0: chars[idx] = 8'($urandom_range(255));
						1: if (chars.size() > 1) chars.delete(idx);
						default: chars.insert(idx, $urandom_range(1) ? random_operator() :
							($urandom_range(1) ? CH_LPAREN : CH_RPAREN));
					endcase
				end
				default: build_expression(chars);
			endcase
			send_chars(chars);
			if ($urandom_range(7) == 0)
				drain_tokens();
		end
	endtask

	task automatic report_field(input string field, input logic [30:0] want,
			input logic [30:0] seen);
		if (want !== seen) begin
			$display("%0t: token %s mismatch: expected %0d, actual %0d",
				$time, field, want, seen);
			mismatch_count++;
		end
	endtask

	// Every token request that completes is checked against the oldest token
	// owed; ready is then redrawn for the next cycle.
	initial begin : token_checker
		tok_t want;
		token_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (token_bus.valid && token_bus.ready) begin
				if (postfix_due.size() == 0) begin
					$display("%0t: token mismatch: expected none, actual kind %0d",
						$time, token_bus.token_kind);
					mismatch_count++;
				end else begin
					want = postfix_due.pop_front();
					report_field("token_kind", want.token_kind, token_bus.token_kind);
					report_field("number_value", want.number_value, token_bus.number_value);
					report_field("variable_index", want.variable_index,
						token_bus.variable_index);
					report_field("operator_code", want.operator_code, token_bus.operator_code);
					report_field("expression_ok", want.expression_ok, token_bus.expression_ok);
					report_field("last_result", want.last_result, token_bus.last_result);
				end
			end
			token_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Ends the run if neither channel moves a request for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((char_bus.valid && char_bus.ready) || (token_bus.valid && token_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("infix_to_postfix_converter_unit_tb: FAIL");
		$finish;
	end

	initial begin
		char_bus.valid     = 1'b0;
		char_bus.char_code = 8'h00;
		char_bus.last_char = 1'b0;
		arst_n             = 1'b0;
		mismatch_count     = 0;
		live_chars         = 0;
		send_gap_pct       = 17;
		recv_stall_pct     = 59;
		clear_converter();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases run with the receiver stalling more than the sender.
		test_precedence();
		test_parentheses();
		test_numbers();
		test_misplaced_tokens();
		test_unknown_chars();
		test_stack_depth();
		test_random_traffic(50);

		// Then the sender is the slow side, and finally nobody idles.
		send_gap_pct   = 59;
		recv_stall_pct = 17;
		test_random_traffic(50);
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_traffic(50);

		drain_tokens();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("infix_to_postfix_converter_unit_tb: PASS");
		else
			$display("infix_to_postfix_converter_unit_tb: FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/core/ifpc_pkg.sv
rtl/core/ifpc_if.sv
rtl/core/ifpc_ram.sv
rtl/core/ifpc_fifo.sv
rtl/core/ifpc_front.sv
rtl/core/ifpc_back.sv
rtl/core/infix_to_postfix_converter_unit.sv
rtl/core/ifpc_checker.sv
tb/sv/infix_to_postfix_converter_unit_tb.sv
